>>> hdl/bmih_pkg.sv
// Shared types, constants and register codes for the battery monitor.
`default_nettype none

package bmih_pkg;

	// Field widths
	localparam int ADC_BITS     = 12;
	localparam int MV_W         = 14;
	localparam int SCALE_W      = 18;
	localparam int ALPHA_W      = 9;
	localparam int HYST_W       = 10;
	localparam int PCT_BITS     = 7;
	localparam int HEALTH_W     = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 18;

	// Fixed-point layout
	localparam int FRAC_BITS_DEF = 8;
	localparam int SCALE_FRAC    = 16;
	localparam int ALPHA_SHIFT   = 8;
	localparam int ALPHA_ONE     = 256;
	localparam int PCT_SCALE     = 100;
	localparam int DIV_STEPS     = PCT_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(105625);
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = ALPHA_W'(26);
	localparam logic [MV_W-1:0]    CRIT_RST     = MV_W'(6600);
	localparam logic [MV_W-1:0]    LOW_RST      = MV_W'(7000);
	localparam logic [MV_W-1:0]    NOMINAL_RST  = MV_W'(7400);
	localparam logic [MV_W-1:0]    FULL_ST_RST  = MV_W'(8000);
	localparam logic [MV_W-1:0]    FULL_PCT_RST = MV_W'(8400);
	localparam logic [HYST_W-1:0]  HYST_RST     = HYST_W'(100);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE    = 3'd0,
		REG_ALPHA    = 3'd1,
		REG_CRIT     = 3'd2,
		REG_LOW      = 3'd3,
		REG_NOMINAL  = 3'd4,
		REG_FULL_ST  = 3'd5,
		REG_FULL_PCT = 3'd6,
		REG_HYST     = 3'd7
	} reg_idx_t;

	// Item commands
	typedef enum logic {
		OP_SEED   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// Health levels, ordered from best to worst
	typedef enum logic [HEALTH_W-1:0] {
		H_FULL = 3'd0,
		H_OK   = 3'd1,
		H_LOW  = 3'd2,
		H_CRIT = 3'd3,
		H_DEAD = 3'd4
	} health_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_MUL,
		ST_SUM,
		ST_CLASS,
		ST_PMUL,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_q16;
		logic [ALPHA_W-1:0] alpha_q8;
		logic [MV_W-1:0]    critical_mv;
		logic [MV_W-1:0]    low_mv;
		logic [MV_W-1:0]    nominal_mv;
		logic [MV_W-1:0]    full_state_mv;
		logic [MV_W-1:0]    full_pct_mv;
		logic [HYST_W-1:0]  hysteresis_mv;
	} cfg_t;

	typedef struct packed {
		logic                cmd;
		logic [ADC_BITS-1:0] raw_sample;
	} in_t;

	typedef struct packed {
		logic [MV_W-1:0]     filtered_mv;
		logic [PCT_BITS-1:0] percent;
		logic [HEALTH_W-1:0] health;
		logic                is_low;
		logic                is_crit;
		logic [ADC_BITS-1:0] last_raw;
		logic                initialised;
	} out_t;

	// Sequencer to datapath
	typedef struct packed {
		logic load_in;
		logic conv;
		logic mul;
		logic sum;
		logic classify;
		logic pmul;
		logic div_step;
		logic write_out;
	} dp_cmd_t;

	// Datapath to sequencer
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/bmih_regs.sv
// Configuration register file for the battery monitor.
`default_nettype none

module bmih_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bmih_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bmih_pkg::CFG_DATA_W-1:0] cfg_data,
	output bmih_pkg::cfg_t                       cfg
);

	bmih_pkg::cfg_t cfg_q;

	// Register writes, each truncated to its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q16     <= bmih_pkg::SCALE_RST;
			cfg_q.alpha_q8      <= bmih_pkg::ALPHA_RST;
			cfg_q.critical_mv   <= bmih_pkg::CRIT_RST;
			cfg_q.low_mv        <= bmih_pkg::LOW_RST;
			cfg_q.nominal_mv    <= bmih_pkg::NOMINAL_RST;
			cfg_q.full_state_mv <= bmih_pkg::FULL_ST_RST;
			cfg_q.full_pct_mv   <= bmih_pkg::FULL_PCT_RST;
			cfg_q.hysteresis_mv <= bmih_pkg::HYST_RST;
		end else if (cfg_we) begin
			unique case (bmih_pkg::reg_idx_t'(cfg_index))
				bmih_pkg::REG_SCALE: begin
					cfg_q.scale_q16 <= cfg_data[bmih_pkg::SCALE_W-1:0];
				end
				bmih_pkg::REG_ALPHA: begin
					cfg_q.alpha_q8 <= cfg_data[bmih_pkg::ALPHA_W-1:0];
				end
				bmih_pkg::REG_CRIT: begin
					cfg_q.critical_mv <= cfg_data[bmih_pkg::MV_W-1:0];
				end
				bmih_pkg::REG_LOW: begin
					cfg_q.low_mv <= cfg_data[bmih_pkg::MV_W-1:0];
				end
				bmih_pkg::REG_NOMINAL: begin
					cfg_q.nominal_mv <= cfg_data[bmih_pkg::MV_W-1:0];
				end
				bmih_pkg::REG_FULL_ST: begin
					cfg_q.full_state_mv <= cfg_data[bmih_pkg::MV_W-1:0];
				end
				bmih_pkg::REG_FULL_PCT: begin
					cfg_q.full_pct_mv <= cfg_data[bmih_pkg::MV_W-1:0];
				end
				bmih_pkg::REG_HYST: begin
					cfg_q.hysteresis_mv <= cfg_data[bmih_pkg::HYST_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/bmih_ctrl.sv
// Sequencer that steps the datapath through one item.
`default_nettype none

module bmih_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire bmih_pkg::dp_sts_t sts,
	output bmih_pkg::dp_cmd_t  cmd
);

	localparam int CW = bmih_pkg::DIV_CNT_W;

	bmih_pkg::state_t state_q, state_d;
	logic [CW-1:0]    div_cnt_q;
	logic             div_last;

	assign div_last = (div_cnt_q == CW'(bmih_pkg::DIV_STEPS - 1));

	// State register and divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bmih_pkg::ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bmih_pkg::ST_DIV && !div_last) begin
				div_cnt_q <= div_cnt_q + CW'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bmih_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = bmih_pkg::ST_CONV;
				end
			end
			bmih_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
				state_d  = bmih_pkg::ST_MUL;
			end
			bmih_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = bmih_pkg::ST_SUM;
			end
			bmih_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = bmih_pkg::ST_CLASS;
			end
			bmih_pkg::ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = bmih_pkg::ST_PMUL;
			end
			bmih_pkg::ST_PMUL: begin
				cmd.pmul = 1'b1;
				state_d  = bmih_pkg::ST_DIV;
			end
			bmih_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_d = bmih_pkg::ST_WRITE;
				end
			end
			bmih_pkg::ST_WRITE: begin
				if (sts.out_free) begin
					cmd.write_out = 1'b1;
					state_d       = bmih_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmih_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/bmih_dp.sv
// Datapath: conversion, IIR filter, health classifier, percent divider, output register.
`default_nettype none

module bmih_dp #(
	parameter int FRAC_BITS = bmih_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bmih_pkg::cfg_t    cfg,
	input  wire bmih_pkg::in_t     in_data,
	input  wire bmih_pkg::dp_cmd_t cmd,
	output bmih_pkg::dp_sts_t  sts,
	output logic               out_valid,
	input  wire logic          out_stall,
	output bmih_pkg::out_t     out_data
);

	localparam int MV_W     = bmih_pkg::MV_W;
	localparam int ACC_W    = MV_W + FRAC_BITS;
	localparam int TW       = ACC_W + 1;
	localparam int PROD_W   = bmih_pkg::ADC_BITS + bmih_pkg::SCALE_W;
	localparam int SHIFT    = bmih_pkg::SCALE_FRAC - FRAC_BITS;
	localparam int AW       = bmih_pkg::ALPHA_W;
	localparam int MUL_W    = ACC_W + AW;
	localparam int SUM_W    = MUL_W + 1;
	localparam int PB       = bmih_pkg::PCT_BITS;
	localparam int NUM_W    = ACC_W + PB;
	localparam int DVS_W    = ACC_W + PB - 1;

	// Item and filter state
	logic                            cmd_q;
	logic [bmih_pkg::ADC_BITS-1:0]   raw_in_q;
	logic [bmih_pkg::ADC_BITS-1:0]   raw_hold_q;
	logic                            seeded_q;
	logic                            commit_q;
	logic [ACC_W-1:0]                acc_q;
	logic [ACC_W-1:0]                conv_q;
	logic [MUL_W-1:0]                mul_new_q;
	logic [MUL_W-1:0]                mul_old_q;
	bmih_pkg::health_t               health_q;

	// Percent path
	logic                            pct_zero_q;
	logic                            pct_full_q;
	logic [ACC_W-1:0]                diff_q;
	logic [NUM_W-1:0]                num_q;
	logic [DVS_W-1:0]                dvs_q;
	logic [PB-1:0]                   quot_q;

	logic                            out_valid_q;
	bmih_pkg::out_t                  out_q;

	// Sample to fixed-point millivolts, saturated
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sh;
	logic [ACC_W-1:0]  conv_d;

	assign prod    = PROD_W'(raw_in_q) * PROD_W'(cfg.scale_q16);
	assign prod_sh = prod >> SHIFT;
	assign conv_d  = (prod_sh > PROD_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}}
	                                                    : prod_sh[ACC_W-1:0];

	// Filter weights, alpha clipped at one
	logic [AW-1:0]    alpha_sat;
	logic [AW-1:0]    alpha_inv;
	logic [SUM_W-1:0] blend;
	logic [ACC_W-1:0] filt_d;

	assign alpha_sat = (cfg.alpha_q8 > AW'(bmih_pkg::ALPHA_ONE)) ?
	                   AW'(bmih_pkg::ALPHA_ONE) : cfg.alpha_q8;
	assign alpha_inv = AW'(bmih_pkg::ALPHA_ONE) - alpha_sat;
	assign blend     = SUM_W'(mul_new_q) + SUM_W'(mul_old_q);
	assign filt_d    = blend[ACC_W+bmih_pkg::ALPHA_SHIFT-1:bmih_pkg::ALPHA_SHIFT];

	// Thresholds at filter resolution
	logic [TW-1:0] v_t;
	logic [TW-1:0] crit_t;
	logic [TW-1:0] low_t;
	logic [TW-1:0] nom_t;
	logic [TW-1:0] full_t;
	logic [TW-1:0] hyst_t;
	bmih_pkg::health_t health_d;

	assign v_t    = TW'(acc_q);
	assign crit_t = TW'({cfg.critical_mv, {FRAC_BITS{1'b0}}});
	assign low_t  = TW'({cfg.low_mv, {FRAC_BITS{1'b0}}});
	assign nom_t  = TW'({cfg.nominal_mv, {FRAC_BITS{1'b0}}});
	assign full_t = TW'({cfg.full_state_mv, {FRAC_BITS{1'b0}}});
	assign hyst_t = TW'({cfg.hysteresis_mv, {FRAC_BITS{1'b0}}});

	// Health classifier: rises and leaving full need the margin; other drops are immediate
	always_comb begin
		health_d = health_q;
		priority if (v_t < crit_t) begin
			health_d = bmih_pkg::H_DEAD;
		end else if (v_t < low_t) begin
			health_d = bmih_pkg::H_CRIT;
		end else begin
			unique case (health_q)
				bmih_pkg::H_DEAD: begin
					health_d = (v_t >= crit_t + hyst_t) ? bmih_pkg::H_CRIT : bmih_pkg::H_DEAD;
				end
				bmih_pkg::H_CRIT: begin
					health_d = (v_t >= low_t + hyst_t) ? bmih_pkg::H_LOW : bmih_pkg::H_CRIT;
				end
				bmih_pkg::H_LOW: begin
					health_d = (v_t >= nom_t + hyst_t) ? bmih_pkg::H_OK : bmih_pkg::H_LOW;
				end
				bmih_pkg::H_OK: begin
					priority if (v_t >= full_t + hyst_t) begin
						health_d = bmih_pkg::H_FULL;
					end else if (v_t < nom_t) begin
						health_d = bmih_pkg::H_LOW;
					end else begin
						health_d = bmih_pkg::H_OK;
					end
				end
				default: begin
					health_d = (v_t + hyst_t < full_t) ? bmih_pkg::H_OK : bmih_pkg::H_FULL;
				end
			endcase
		end
	end

	// Percent span and offset
	logic [ACC_W-1:0] zero_fx;
	logic [MV_W-1:0]  span_mv;
	logic [ACC_W-1:0] span_fx;
	logic [ACC_W-1:0] diff_d;
	logic             span_ok;

	assign zero_fx = {cfg.critical_mv, {FRAC_BITS{1'b0}}};
	assign span_ok = cfg.full_pct_mv > cfg.critical_mv;
	assign span_mv = cfg.full_pct_mv - cfg.critical_mv;
	assign span_fx = {span_mv, {FRAC_BITS{1'b0}}};
	assign diff_d  = acc_q - zero_fx;

	// Restoring divider step
	logic             div_ge;
	assign div_ge = num_q >= NUM_W'(dvs_q);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= in_data.cmd;
			raw_in_q <= in_data.raw_sample;
		end
		if (cmd.conv) begin
			conv_q   <= conv_d;
			commit_q <= (cmd_q == bmih_pkg::OP_SEED) || seeded_q;
		end
		if (cmd.mul) begin
			mul_new_q <= MUL_W'(alpha_sat) * MUL_W'(conv_q);
			mul_old_q <= MUL_W'(alpha_inv) * MUL_W'(acc_q);
		end
		if (cmd.classify) begin
			pct_zero_q <= !span_ok || (acc_q <= zero_fx);
			pct_full_q <= diff_d >= span_fx;
			diff_q     <= diff_d;
			dvs_q      <= DVS_W'({span_fx, {(PB-1){1'b0}}});
		end
		if (cmd.pmul) begin
			num_q  <= NUM_W'(diff_q) * NUM_W'(bmih_pkg::PCT_SCALE);
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			if (div_ge) begin
				num_q <= num_q - NUM_W'(dvs_q);
			end
			dvs_q  <= dvs_q >> 1;
			quot_q <= {quot_q[PB-2:0], div_ge};
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			health_q   <= bmih_pkg::H_OK;
			seeded_q   <= 1'b0;
			raw_hold_q <= '0;
		end else begin
			if (cmd.sum && commit_q) begin
				acc_q      <= (cmd_q == bmih_pkg::OP_SEED) ? conv_q : filt_d;
				raw_hold_q <= raw_in_q;
				if (cmd_q == bmih_pkg::OP_SEED) begin
					seeded_q <= 1'b1;
				end
			end
			if (cmd.classify && commit_q) begin
				health_q <= health_d;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			out_q.filtered_mv <= acc_q[ACC_W-1:FRAC_BITS];
			out_q.percent     <= pct_zero_q ? '0 :
			                     pct_full_q ? PB'(bmih_pkg::PCT_SCALE) : quot_q;
			out_q.health      <= health_q;
			out_q.is_low      <= health_q >= bmih_pkg::H_LOW;
			out_q.is_crit     <= health_q >= bmih_pkg::H_CRIT;
			out_q.last_raw    <= raw_hold_q;
			out_q.initialised <= seeded_q;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// Checks
	a_acc_only_on_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.sum) |-> $stable(acc_q))
		else $error("filter state changed outside the update step");

	a_seeded_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag dropped");

	a_write_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> sts.out_free)
		else $error("output register overwritten while a beat waits");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.percent <= PB'(bmih_pkg::PCT_SCALE)))
		else $error("percent out of range");

endmodule

`default_nettype wire

>>> hdl/battery_monitor_iir_hysteresis.sv
// The sequencer handles one item at a time: it takes no new sample until the last
// is through conversion, multiply, sum, classify, percent multiply, the 7-step
// restoring divider and the write to the output register, which waits for room.
// A finished beat may wait in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): registers return to their default values,
// the filter is unseeded at zero, health reads ok and no output beat is pending.
`default_nettype none

module battery_monitor_iir_hysteresis #(
	parameter int FRAC_BITS = bmih_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire bmih_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output bmih_pkg::out_t                       out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bmih_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bmih_pkg::CFG_DATA_W-1:0] cfg_data
);

	bmih_pkg::cfg_t    cfg;
	bmih_pkg::dp_cmd_t cmd;
	bmih_pkg::dp_sts_t sts;

	// Configuration registers
	bmih_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer
	bmih_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	bmih_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> verif/bmih_checker.sv
// Battery monitor checker: predicts each reading from the sample stream and compares.
`timescale 1ns / 100ps

module bmih_checker
	import bmih_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  in_t                        in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending
);

	localparam int FB = FRAC_BITS_DEF;
	localparam int ACC_W = MV_W + FB;
	localparam logic [63:0] ACC_TOP = (64'd1 << ACC_W) - 64'd1;

	// Shadow registers and filter state
	cfg_t             regs;
	logic [ACC_W-1:0] acc_q;
	health_t          health_q;
	logic             seeded_q;
	logic [ADC_BITS-1:0] raw_q;

	out_t expected_readings[$];
	int   beat_no;

	function automatic logic [63:0] fix(logic [63:0] mv);
		return mv << FB;
	endfunction

	// ADC count to fixed-point millivolts, saturated
	function automatic logic [63:0] mv_from_raw(logic [ADC_BITS-1:0] raw);
		logic [63:0] v;
		v = (64'(raw) * 64'(regs.scale_q16)) >> (SCALE_FRAC - FB);
		return (v > ACC_TOP) ? ACC_TOP : v;
	endfunction

	// Downward checks immediate except leaving full; upward moves need the margin
	function automatic health_t next_health(logic [63:0] v);
		logic [63:0] h;
		h = fix(64'(regs.hysteresis_mv));
		if (v < fix(64'(regs.critical_mv))) return H_DEAD;
		if (v < fix(64'(regs.low_mv))) return H_CRIT;
		case (health_q)
			H_DEAD: return (v >= fix(64'(regs.critical_mv)) + h) ? H_CRIT : H_DEAD;
			H_CRIT: return (v >= fix(64'(regs.low_mv)) + h) ? H_LOW : H_CRIT;
			H_LOW:  return (v >= fix(64'(regs.nominal_mv)) + h) ? H_OK : H_LOW;
			H_OK: begin
				if (v >= fix(64'(regs.full_state_mv)) + h) return H_FULL;
				if (v < fix(64'(regs.nominal_mv))) return H_LOW;
				return H_OK;
			end
			default: return (v + h < fix(64'(regs.full_state_mv))) ? H_OK : H_FULL;
		endcase
	endfunction

	// State of charge, exact integer division, clamped
	function automatic logic [PCT_BITS-1:0] charge_percent(logic [63:0] v);
		logic [63:0] zero, span, p;
		zero = fix(64'(regs.critical_mv));
		if (regs.full_pct_mv <= regs.critical_mv) return '0;
		if (v <= zero) return '0;
		span = fix(64'(regs.full_pct_mv) - 64'(regs.critical_mv));
		p = ((v - zero) * 64'(PCT_SCALE)) / span;
		return (p > 64'(PCT_SCALE)) ? PCT_BITS'(PCT_SCALE) : p[PCT_BITS-1:0];
	endfunction

	task automatic predict_reading(in_t d);
		logic [63:0] a, x;
		out_t e;
		if (d.cmd == OP_SEED) begin
			raw_q    = d.raw_sample;
			acc_q    = ACC_W'(mv_from_raw(d.raw_sample));
			health_q = next_health(64'(acc_q));
			seeded_q = 1'b1;
		end else if (seeded_q) begin
			a = (regs.alpha_q8 > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(regs.alpha_q8);
			x = mv_from_raw(d.raw_sample);
			raw_q    = d.raw_sample;
			acc_q    = ACC_W'(((a * x + (64'(ALPHA_ONE) - a) * 64'(acc_q)) >> ALPHA_SHIFT)
				& ACC_TOP);
			health_q = next_health(64'(acc_q));
		end
		e.filtered_mv = acc_q[ACC_W-1:FB];
		e.percent     = charge_percent(64'(acc_q));
		e.health      = health_q;
		e.is_low      = (health_q >= H_LOW);
		e.is_crit     = (health_q >= H_CRIT);
		e.last_raw    = raw_q;
		e.initialised = seeded_q;
		expected_readings.push_back(e);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (fails < 10)
				$display("%t: reading %0d %s mismatch: expected %0d, got %0d",
					$realtime, beat_no, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.scale_q16     = SCALE_RST;
			regs.alpha_q8      = ALPHA_RST;
			regs.critical_mv   = CRIT_RST;
			regs.low_mv        = LOW_RST;
			regs.nominal_mv    = NOMINAL_RST;
			regs.full_state_mv = FULL_ST_RST;
			regs.full_pct_mv   = FULL_PCT_RST;
			regs.hysteresis_mv = HYST_RST;
			acc_q    = '0;
			health_q = H_OK;
			seeded_q = 1'b0;
			raw_q    = '0;
			expected_readings.delete();
			beat_no  = 0;
			fails    = 0;
			pending  = 0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SCALE:    regs.scale_q16     = cfg_data[SCALE_W-1:0];
					REG_ALPHA:    regs.alpha_q8      = cfg_data[ALPHA_W-1:0];
					REG_CRIT:     regs.critical_mv   = cfg_data[MV_W-1:0];
					REG_LOW:      regs.low_mv        = cfg_data[MV_W-1:0];
					REG_NOMINAL:  regs.nominal_mv    = cfg_data[MV_W-1:0];
					REG_FULL_ST:  regs.full_state_mv = cfg_data[MV_W-1:0];
					REG_FULL_PCT: regs.full_pct_mv   = cfg_data[MV_W-1:0];
					REG_HYST:     regs.hysteresis_mv = cfg_data[HYST_W-1:0];
					default: ;
				endcase
			end
			// Result beats against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					if (fails < 10)
						$display("%t: reading %0d arrived with nothing predicted: %p",
							$realtime, beat_no, out_data);
					fails++;
				end else begin
					check_field("filtered_mv", 32'(expected_readings[0].filtered_mv),
						32'(out_data.filtered_mv));
					check_field("percent", 32'(expected_readings[0].percent),
						32'(out_data.percent));
					check_field("health", 32'(expected_readings[0].health),
						32'(out_data.health));
					check_field("is_low", 32'(expected_readings[0].is_low),
						32'(out_data.is_low));
					check_field("is_crit", 32'(expected_readings[0].is_crit),
						32'(out_data.is_crit));
					check_field("last_raw", 32'(expected_readings[0].last_raw),
						32'(out_data.last_raw));
					check_field("initialised", 32'(expected_readings[0].initialised),
						32'(out_data.initialised));
					void'(expected_readings.pop_front());
				end
				beat_no++;
			end
			// Sample beats
			if (in_valid && !in_stall)
				predict_reading(in_data);
			pending = expected_readings.size();
		end
	end

endmodule

>>> verif/tb.sv
// Top-level testbench for the battery monitor: reset, register settings, samples, verdict.
`timescale 1ns / 100ps

module tb;
	import bmih_pkg::*;

	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 304;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fails, pending;
	int src_idle = 20;
	int sink_idle = 51;
	int quiet_cycles = 0;
	int samples = 0, seeds = 0, readings = 0, settings = 0;

	battery_monitor_iir_hysteresis uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bmih_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < sink_idle);

	// Activity tracking for the watchdog and the summary
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (out_valid && !out_stall)
			readings <= readings + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// One sample beat; valid stays high on return
	task automatic send(op_t op, int raw);
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.cmd <= op;
		in_data.raw_sample <= raw[ADC_BITS-1:0];
		do @(posedge clk); while (in_stall);
		samples++;
		if (op == OP_SEED) seeds++;
	endtask

	// Hold off until every reading is back and the sequencer has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(cfg_t c);
		reg_idx_t idx;
		logic [CFG_DATA_W-1:0] val;
		for (int k = 0; k < 8; k++) begin
			idx = reg_idx_t'(k);
			case (idx)
				REG_SCALE:    val = CFG_DATA_W'(c.scale_q16);
				REG_ALPHA:    val = CFG_DATA_W'(c.alpha_q8);
				REG_CRIT:     val = CFG_DATA_W'(c.critical_mv);
				REG_LOW:      val = CFG_DATA_W'(c.low_mv);
				REG_NOMINAL:  val = CFG_DATA_W'(c.nominal_mv);
				REG_FULL_ST:  val = CFG_DATA_W'(c.full_state_mv);
				REG_FULL_PCT: val = CFG_DATA_W'(c.full_pct_mv);
				default:      val = CFG_DATA_W'(c.hysteresis_mv);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic cfg_t default_settings();
		cfg_t c;
		c.scale_q16     = SCALE_RST;
		c.alpha_q8      = ALPHA_RST;
		c.critical_mv   = CRIT_RST;
		c.low_mv        = LOW_RST;
		c.nominal_mv    = NOMINAL_RST;
		c.full_state_mv = FULL_ST_RST;
		c.full_pct_mv   = FULL_PCT_RST;
		c.hysteresis_mv = HYST_RST;
		return c;
	endfunction

	function automatic int clamp_mv(int v);
		return (v > 16383) ? 16383 : v;
	endfunction

	// Thresholds stacked upward from a start in the lower half of the reachable voltage range, now and then scrambled
	function automatic cfg_t random_settings();
		cfg_t c;
		int vmax, span, t;
		c.scale_q16 = SCALE_W'($urandom_range(20000, 262143));
		vmax = (4095 * int'(c.scale_q16)) >>> 16;
		span = vmax / 6 + 1;
		if ($urandom_range(0, 3) == 0)
			c.alpha_q8 = ALPHA_W'($urandom_range(0, 511));
		else
			c.alpha_q8 = ALPHA_W'($urandom_range(16, 256));
		t = $urandom_range(0, vmax / 2);
		c.critical_mv = MV_W'(clamp_mv(t));
		t += $urandom_range(0, span);
		c.low_mv = MV_W'(clamp_mv(t));
		t += $urandom_range(0, span);
		c.nominal_mv = MV_W'(clamp_mv(t));
		t += $urandom_range(0, span);
		c.full_state_mv = MV_W'(clamp_mv(t));
		t += $urandom_range(0, span);
		c.full_pct_mv = MV_W'(clamp_mv(t));
		c.hysteresis_mv = HYST_W'($urandom_range(0, (span / 2 > 1023) ? 1023 : span / 2));
		if ($urandom_range(0, 7) == 0) begin
			c.critical_mv   = MV_W'($urandom_range(0, 16383));
			c.low_mv        = MV_W'($urandom_range(0, 16383));
			c.nominal_mv    = MV_W'($urandom_range(0, 16383));
			c.full_state_mv = MV_W'($urandom_range(0, 16383));
			c.full_pct_mv   = MV_W'($urandom_range(0, 16383));
			c.hysteresis_mv = HYST_W'($urandom_range(0, 1023));
		end
		return c;
	endfunction

	initial begin
		cfg_t c;
		int target, raw_i, pick;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: updates before any seed, then seeds at both ends
		send(OP_UPDATE, 4095);
		send(OP_UPDATE, 0);
		send(OP_SEED, 0);
		send(OP_SEED, 4095);
		send(OP_UPDATE, 4095);
		send(OP_UPDATE, 0);

		// Wide range, alpha one: climb to full, then fall through every level
		settle();
		c = default_settings();
		c.scale_q16 = SCALE_W'(144037);
		c.alpha_q8 = ALPHA_W'(ALPHA_ONE);
		load_settings(c);
		send(OP_SEED, 4095);
		repeat (3) send(OP_UPDATE, 4095);
		send(OP_UPDATE, 3550);
		send(OP_UPDATE, 3300);
		send(OP_UPDATE, 3100);
		send(OP_UPDATE, 2900);
		send(OP_UPDATE, 3050);

		// Every register at its top; alpha beyond one, empty percent span
		settle();
		c.scale_q16 = '1;
		c.alpha_q8 = '1;
		c.critical_mv = '1;
		c.low_mv = '1;
		c.nominal_mv = '1;
		c.full_state_mv = '1;
		c.full_pct_mv = '1;
		c.hysteresis_mv = '1;
		load_settings(c);
		send(OP_SEED, 4095);
		send(OP_UPDATE, 0);
		send(OP_UPDATE, 4095);

		// Every register at zero
		settle();
		load_settings('0);
		send(OP_UPDATE, 1234);
		send(OP_SEED, 4095);

		// Margin larger than the full threshold: full never drops back to ok
		settle();
		c = '0;
		c.scale_q16 = SCALE_W'(144037);
		c.alpha_q8 = ALPHA_W'(ALPHA_ONE);
		c.full_state_mv = MV_W'(50);
		c.full_pct_mv = MV_W'(9000);
		c.hysteresis_mv = '1;
		load_settings(c);
		send(OP_SEED, 4095);
		repeat (3) send(OP_UPDATE, 4095);
		send(OP_UPDATE, 0);

		// Random phases: slow drifting sample streams with seeds and noise mixed in
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 2) begin
				src_idle = 51;
				sink_idle = 20;
			end else if (ph == 4) begin
				src_idle = 0;
				sink_idle = 0;
			end
			settle();
			load_settings(random_settings());
			target = $urandom_range(0, 4095);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					settle();
				if ($urandom_range(0, 15) == 0)
					target = $urandom_range(0, 4095);
				else
					target = target + int'($urandom_range(0, 40)) - 20;
				if (target < 0) target = 0;
				if (target > 4095) target = 4095;
				pick = $urandom_range(0, 99);
				if (pick >= 94) begin
					raw_i = $urandom_range(0, 4095);
				end else begin
					raw_i = target + int'($urandom_range(0, 16)) - 8;
					if (raw_i < 0) raw_i = 0;
					if (raw_i > 4095) raw_i = 4095;
				end
				send((pick < 6) ? OP_SEED : OP_UPDATE, raw_i);
			end
		end

		settle();
		$display("Covered %0d samples (%0d seeds) and %0d readings over %0d register settings,",
			samples, seeds, readings, settings);
		$display("with sender-heavy, receiver-heavy and no back-pressure stall patterns.");
		if (pending != 0)
			$display("%0d predicted readings never arrived", pending);
		if (fails == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
